// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Each macro expects the clock clk in scope; BDSL_ASSERT also the active-low reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, suspended while reset is low.
`define BDSL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// Property checked at every rising clock edge, including during reset.
`define BDSL_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

// ===== sv/bdsl_pkg.sv =====
// Package of the push-button debouncer: counter widths, register indexes,
// the configuration and result structs, and the saturating increment.
// No dependencies.
`default_nettype none

package bdsl_pkg;

	// Width of the quiet and hold counters.
	localparam int CNT_W = 16;
	// Width at which hold counts and the long threshold are compared.
	localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd1;

	// Register reset values.
	localparam logic [7:0]  DEBOUNCE_RST   = 8'd50;
	localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CMP_W-1:0] cmp_t;

	localparam cnt_t CNT_MAX = '1;

	// Current register settings.
	typedef struct packed {
		logic [7:0]  debounce_ms;
		logic [15:0] long_press_ms;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic stable_level;
		logic long_pulse;
		logic short_pulse;
		logic press_pulse;
	} res_t;

	// Counter increment that sticks at the all-ones value.
	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

endpackage

`default_nettype wire

// ===== sv/bdsl_cfg.sv =====
// Configuration registers of the debouncer: debounce window and long threshold.
// Depends on bdsl_pkg.
`default_nettype none

module bdsl_cfg (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [bdsl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [bdsl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output bdsl_pkg::cfg_t                    cfg
);

	logic [7:0]  debounce_q;
	logic [15:0] long_press_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bdsl_pkg::DEBOUNCE_RST;
			long_press_q <= bdsl_pkg::LONG_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdsl_pkg::REG_DEBOUNCE_MS: begin
					debounce_q <= cfg_wdata[7:0];
				end
				bdsl_pkg::REG_LONG_PRESS_MS: begin
					long_press_q <= cfg_wdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.debounce_ms   = debounce_q;
	assign cfg.long_press_ms = long_press_q;

endmodule

`default_nettype wire

// ===== sv/bdsl_core.sv =====
// Debounce and press classification state, updated once per accepted tick.
// Depends on bdsl_pkg.
`default_nettype none

module bdsl_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              tick,
	input  wire              raw,
	input  bdsl_pkg::cfg_t   cfg,
	output bdsl_pkg::res_t   res
);

	logic             prev_raw_q;
	bdsl_pkg::cnt_t   quiet_q;
	logic             debounced_q;
	bdsl_pkg::cnt_t   hold_q;
	logic             armed_q;

	bdsl_pkg::cnt_t   hold_inc;
	bdsl_pkg::cnt_t   quiet_d;
	bdsl_pkg::cnt_t   hold_d;
	logic             debounced_d;
	logic             armed_d;
	logic             settled;
	logic             press;
	logic             shrt;
	logic             lng;
	logic             hold_short;
	logic             hold_long;

	// Next state and pulses for the current tick.
	always_comb begin
		hold_inc    = debounced_q ? bdsl_pkg::sat_inc(hold_q) : hold_q;
		quiet_d     = (raw != prev_raw_q) ? '0 : bdsl_pkg::sat_inc(quiet_q);
		settled     = quiet_d > bdsl_pkg::cnt_t'(cfg.debounce_ms);
		hold_short  = bdsl_pkg::cmp_t'(hold_inc) < bdsl_pkg::cmp_t'(cfg.long_press_ms);
		hold_d      = hold_inc;
		debounced_d = debounced_q;
		armed_d     = armed_q;
		press       = 1'b0;
		shrt        = 1'b0;
		lng         = 1'b0;

		// Accepted level change: a press arms the long detector, a release
		// reports a short hold.
		if (settled && (raw != debounced_q)) begin
			debounced_d = raw;
			hold_d      = '0;
			armed_d     = raw;
			press       = raw;
			shrt        = !raw && hold_short;
		end

		// Long hold fires once per press.
		hold_long = bdsl_pkg::cmp_t'(hold_d) >= bdsl_pkg::cmp_t'(cfg.long_press_ms);
		if (settled && debounced_d && armed_d && hold_long) begin
			lng     = 1'b1;
			armed_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q  <= 1'b0;
			quiet_q     <= '0;
			debounced_q <= 1'b0;
			hold_q      <= '0;
			armed_q     <= 1'b0;
		end else if (tick) begin
			prev_raw_q  <= raw;
			quiet_q     <= quiet_d;
			debounced_q <= debounced_d;
			hold_q      <= hold_d;
			armed_q     <= armed_d;
		end
	end

	assign res.press_pulse  = press;
	assign res.short_pulse  = shrt;
	assign res.long_pulse   = lng;
	assign res.stable_level = debounced_d;

endmodule

`default_nettype wire

// ===== sv/bdsl_outreg.sv =====
// Output register of the debouncer's result stream with its handshake.
// Depends on bdsl_pkg.
`default_nettype none

module bdsl_outreg (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              load,
	input  bdsl_pkg::res_t   res,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	output bdsl_pkg::res_t   out_res
);

	logic            valid_q;
	bdsl_pkg::res_t  res_q;

	// A new result may enter when the register is empty or drains this cycle.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_ready) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire

// ===== sv/button_debounce_short_long_press.sv =====
// Push-button debouncer with short and long press detection.
// Instantiates bdsl_cfg, bdsl_core and bdsl_outreg; depends on bdsl_pkg.
//
// Usage:
//   Each request on the s_axis channel is one millisecond tick carrying the
//   raw button level in bit 0 of s_axis_tdata (1 means pressed).
//   Each tick yields exactly one request on the m_axis channel with the
//   press, short and long pulses and the debounced level.
//   Each result is on m_axis in the cycle after its tick is accepted.
//   Throughput is one tick per cycle while m_axis_tready stays high; the core
//   counters and compares and a single output register sit between the
//   two channels. When the receiver stalls, the result waits in the output
//   register and s_axis_tready drops until that result is taken.
//   Reset clears the counters, the debounced level and the output valid, and
//   loads the registers with a debounce window of 50 and a long threshold of
//   1000 ticks. The user writes registers through cfg_we, cfg_index and
//   cfg_wdata only while no tick is in flight; unchecked by the block.
`default_nettype none

module button_debounce_short_long_press (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [bdsl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [bdsl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [7:0]                       s_axis_tdata,  // [0] raw_pressed
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// [0] press_pulse, [1] short_pulse, [2] long_pulse, [3] stable_level
	output logic [7:0]                       m_axis_tdata
);

	bdsl_pkg::cfg_t  cfg;
	bdsl_pkg::res_t  res;
	bdsl_pkg::res_t  out_res;
	logic            tick;

	assign tick = s_axis_tvalid && s_axis_tready;

	bdsl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bdsl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.raw    (s_axis_tdata[0]),
		.cfg    (cfg),
		.res    (res)
	);

	bdsl_outreg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s_axis_tvalid),
		.res       (res),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Result fields from the lowest bit up, zero padded to a byte.
	assign m_axis_tdata = {4'b0000, out_res};

endmodule

`default_nettype wire

// ===== sv/bdsl_checker.sv =====
// Port-level checks of the push-button debouncer, bound to its top level.
// Depends on assert_macros.svh and bdsl_pkg.
`default_nettype none
`include "assert_macros.svh"

module bdsl_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              cfg_we,
	input wire  [bdsl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input wire  [bdsl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input wire                              s_axis_tvalid,
	input wire                              s_axis_tready,
	input wire  [7:0]                       s_axis_tdata,
	input wire                              m_axis_tvalid,
	input wire                              m_axis_tready,
	input wire  [7:0]                       m_axis_tdata
);

	// A stalled result stays offered.
	`BDSL_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	// Every accepted tick shows a result in the next cycle.
	`BDSL_ASSERT(a_tick_result, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
	// A press pulse comes with the pressed level, a short pulse with release.
	`BDSL_ASSERT(a_press_level, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3])
	`BDSL_ASSERT(a_short_level, m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[3])
	// No result is offered while reset is held.
	`BDSL_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_axis_tvalid)

endmodule

bind button_debounce_short_long_press bdsl_checker u_bdsl_checker (.*);

`default_nettype wire

// ===== verif/tb_button_debounce_short_long_press.sv =====
`timescale 1ns / 1ps
// Testbench of button_debounce_short_long_press: a tick predictor with a result queue
// checks every result item. Depends on bdsl_pkg and the block's RTL only.

// Tracks the debouncer state and keeps the expected pulse items in order.
class press_event_board;
	typedef bit [bdsl_pkg::CNT_W-1:0] count_t;

	bit [7:0]  debounce_ms;
	bit [15:0] long_ms;
	bit        last_raw;
	count_t    quiet;
	bit        level;
	count_t    hold;
	bit        armed;

	bdsl_pkg::res_t expected_pulses[$];
	int mismatches;
	int ticks_noted;
	int results_seen;
	int press_seen, short_seen, long_seen;

	function new();
		debounce_ms = bdsl_pkg::DEBOUNCE_RST;
		long_ms     = bdsl_pkg::LONG_PRESS_RST;
		last_raw    = 1'b0;
		quiet       = '0;
		level       = 1'b0;
		hold        = '0;
		armed       = 1'b0;
		mismatches  = 0;
	endfunction

	// Counters stop at all ones.
	function count_t bump(count_t v);
		if (&v)
			return v;
		return v + 1'b1;
	endfunction

	// Mirror of a register write; unknown indexes leave the settings alone.
	function void apply_reg(logic [bdsl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
		case (idx)
			bdsl_pkg::REG_DEBOUNCE_MS:   debounce_ms = data[7:0];
			bdsl_pkg::REG_LONG_PRESS_MS: long_ms = data;
			default: ;
		endcase
	endfunction

	// One accepted tick: advance the state and queue the pulses it causes.
	function void note_tick(bit raw);
		bdsl_pkg::res_t r;
		r = '0;
		if (level)
			hold = bump(hold);
		if (raw != last_raw) begin
			last_raw = raw;
			quiet = '0;
		end else begin
			quiet = bump(quiet);
		end
		// The debounced level and the long check only move once the raw level is quiet.
		if (quiet > debounce_ms) begin
			if (raw != level) begin
				level = raw;
				if (raw) begin
					hold = '0;
					armed = 1'b1;
					r.press_pulse = 1'b1;
				end else begin
					r.short_pulse = (hold < long_ms);
					hold = '0;
					armed = 1'b0;
				end
			end
			if (level && armed && hold >= long_ms) begin
				r.long_pulse = 1'b1;
				armed = 1'b0;
			end
		end
		r.stable_level = level;
		press_seen += r.press_pulse;
		short_seen += r.short_pulse;
		long_seen += r.long_pulse;
		ticks_noted++;
		expected_pulses.push_back(r);
	endfunction

	function void compare_bit(string name, bit want, logic got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 20)
				$error("%s: expected %0d, got %0b", name, want, got);
		end
	endfunction

	// One accepted result request, checked against the oldest expectation.
	function void check_result(logic [7:0] data);
		bdsl_pkg::res_t want;
		bdsl_pkg::res_t got;
		got = data[3:0];
		results_seen++;
		if (expected_pulses.size() == 0) begin
			mismatches++;
			if (mismatches <= 20)
				$error("result %h arrived with no tick waiting for it", data);
			return;
		end
		want = expected_pulses.pop_front();
		compare_bit("press_pulse", want.press_pulse, got.press_pulse);
		compare_bit("short_pulse", want.short_pulse, got.short_pulse);
		compare_bit("long_pulse", want.long_pulse, got.long_pulse);
		compare_bit("stable_level", want.stable_level, got.stable_level);
	endfunction

	function int pending();
		return expected_pulses.size();
	endfunction
endclass

module tb_button_debounce_short_long_press;

	// Indexes past the two registers; writes there must change nothing.
	localparam logic [bdsl_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [bdsl_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_TICKS = 200;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bdsl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bdsl_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [7:0]                      s_axis_tdata;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [7:0]                      m_axis_tdata;

	press_event_board board = new();
	bit calm_src;
	bit calm_sink;
	int tick_count;
	int settings_used;
	int dead_cycles;

	button_debounce_short_long_press dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle stretch length: mostly none, sometimes short, rarely long.
	function automatic int gap_len(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Receiver side: ready drops for random stretches.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall == 0)
				stall = gap_len(calm_sink);
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Monitor of both channels, plus a watchdog on cycles with no request moving.
	always @(posedge clk) begin
		if (!arst_n) begin
			dead_cycles = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_tick(s_axis_tdata[0]);
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				dead_cycles = 0;
			else
				dead_cycles++;
			if (dead_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// One tick request; the upper data bits carry junk that the block must ignore.
	task automatic send_tick(input bit raw);
		int gap;
		int unsigned r;
		gap = gap_len(calm_src);
		r = $urandom;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {r[6:0], raw};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		tick_count++;
	endtask

	task automatic run_level(input bit raw, input int n);
		repeat (n) send_tick(raw);
	endtask

	// Ticks given as a string of 0 and 1 characters, first tick first.
	task automatic send_pattern(input string s);
		for (int i = 0; i < s.len(); i++)
			send_tick(s.getc(i) == "1");
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bdsl_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.apply_reg(idx, data);
	endtask

	// New settings; junk sits above the debounce field and sometimes goes to a spare index.
	task automatic set_config(input int d, input int l);
		int unsigned r;
		r = $urandom;
		settle();
		write_reg(bdsl_pkg::REG_DEBOUNCE_MS, {r[7:0], d[7:0]});
		if (r[8])
			write_reg(r[9] ? REG_SPARE_A : REG_SPARE_B, r[31:16]);
		write_reg(bdsl_pkg::REG_LONG_PRESS_MS, l[15:0]);
		settings_used++;
		calm_src = ($urandom_range(0, 3) == 0);
		calm_sink = ($urandom_range(0, 3) == 0);
	endtask

	// Contact bounce, each run too short to pass the debounce window on its own.
	task automatic bounce(input int d);
		repeat ($urandom_range(0, 4))
			run_level(bit'($urandom_range(0, 1)), $urandom_range(1, d + 1));
	endtask

	// A full press: bounce, a hold below, near or past the long threshold, bounce, a release.
	task automatic press_seq(input int d, input int l);
		int extra;
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			extra = $urandom_range(0, (l > 0) ? l - 1 : 0);
		else if (r < 80)
			extra = (l > 0) ? l - 1 + $urandom_range(0, 2) : $urandom_range(0, 2);
		else
			extra = l + $urandom_range(0, 10);
		if (extra > 40)
			extra = $urandom_range(0, 40);
		bounce(d);
		run_level(1'b1, d + 2 + extra);
		bounce(d);
		run_level(1'b0, d + 2 + $urandom_range(0, 5));
	endtask

	initial begin
		int start;
		int d;
		int l;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero window and zero threshold: long fires on the press tick, no short ever.
		write_reg(bdsl_pkg::REG_DEBOUNCE_MS, 16'hA500);
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h0007);
		write_reg(bdsl_pkg::REG_LONG_PRESS_MS, 16'd0);
		settings_used = 1;
		send_pattern("11100101100");

		// One-tick window with a short threshold: long on the first press only, no short.
		settle();
		write_reg(bdsl_pkg::REG_DEBOUNCE_MS, 16'h5A01);
		write_reg(bdsl_pkg::REG_LONG_PRESS_MS, 16'd2);
		settings_used++;
		send_pattern("111111000111000");

		// Random settings, mostly small, with well-formed presses and some noise.
		start = tick_count;
		while (tick_count - start < RANDOM_TICKS) begin
			case ($urandom_range(0, 9))
				0, 1:    d = 0;
				2:       d = 1;
				default: d = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 19))
				0, 1:    l = 0;
				2, 3, 4: l = 1;
				5, 6:    l = 65535;
				default: l = $urandom_range(2, 40);
			endcase
			set_config(d, l);
			repeat ($urandom_range(4, 10)) begin
				if (tick_count - start >= RANDOM_TICKS)
					break;
				if ($urandom_range(0, 3) != 0)
					press_seq(d, l);
				else
					repeat ($urandom_range(1, 12)) send_tick(bit'($urandom_range(0, 1)));
				// Now and then hold off until the result queue runs dry.
				if ($urandom_range(0, 9) == 0)
					settle();
			end
		end

		// Widest window and highest threshold: the press is taken only after
		// 256 quiet ticks, and the long threshold stays out of reach.
		set_config(255, 65535);
		run_level(1'b1, 258);

		settle();
		repeat (5) @(posedge clk);
		$display("summary: %0d ticks over %0d register settings, %0d results checked",
			board.ticks_noted, settings_used, board.results_seen);
		$display("summary: %0d press, %0d short, %0d long pulses expected",
			board.press_seen, board.short_seen, board.long_seen);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
